/* hw/rtl/ufe_pkg.sv */
// ----------------------------------------------------------------------------
// ufe_pkg
// Types and constants shared by the union-find engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

	localparam int CMD_W   = 2;
	localparam int NODE_W  = 10;
	localparam int CNT_W   = 11;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_MERGE = 2'd0,
		CMD_SAME  = 2'd1,
		CMD_FIND  = 2'd2,
		CMD_SIZE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_COMP,
		ST_LINK,
		ST_SIZE,
		ST_RESP
	} state_t;

endpackage

/* hw/rtl/union_find_engine_core.sv */
// ----------------------------------------------------------------------------
// union_find_engine_core
// Disjoint-set engine, union by size with path compression, one request at a
// time over a single node table memory.
// ----------------------------------------------------------------------------
// usage:
//   s_tvalid/s_tready/s_tdata carry requests (command, node_a, node_b); one
//   result per request leaves on m_tvalid/m_tready/m_tdata.
//   cfg_we with cfg_wdata writes node_count and clears the table.
// sequence:
//   s_tready is high only while idle. An accepted request is checked for
//   range, then node_a's parent chain is walked to its root and every node
//   on the path is pointed straight at that root; merge and same repeat this
//   for node_b, and a merge of two different sets then links one root under
//   the other and writes the summed size. A walk step and a compression
//   write each use the table's one read port and one write port. An
//   out-of-range request goes from the check straight to the result. The
//   result turns valid as s_tready rises.
// reset and configuration:
//   after reset and after every node_count write the table is swept back to
//   singletons, one entry a cycle; no request is taken meanwhile.
// stalls:
//   the result sits in an output register; while the receiver holds
//   m_tready low the engine waits with the next result before going idle.
// ----------------------------------------------------------------------------
module union_find_engine_core
	import ufe_pkg::*;
#(
	parameter int MAX_NODES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,  // node_count
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,    // cmd[1:0], node_a[11:2], node_b[21:12], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata     // root_node[9:0], same_set[10], set_size[21:11],
	                                     // index_error[22], zero pad
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int ENT_W = CNT_W + IDX_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  node_count_q;
	logic [IDX_W-1:0]  clr_q;
	cmd_t              cmd_q;
	logic [NODE_W-1:0] a_q, b_q;
	logic              phase_q;
	logic [IDX_W-1:0]  cur_q, node_q, root_q, ra_q;
	logic [CNT_W-1:0]  rcnt_q, ca_q;
	logic [NODE_W-1:0] res_root_q;
	logic              res_same_q, res_err_q;
	logic [CNT_W-1:0]  res_size_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// table entry: {set size (valid at roots only), parent link}
	logic [ENT_W-1:0]  table_q [MAX_NODES];
	logic [ENT_W-1:0]  rdata_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [ENT_W-1:0]  mem_wdata;

	logic              s_accept, out_free, two, is_merge, idx_err, rd_root;
	logic [IDX_W-1:0]  rd_parent, start_idx, idx_a, idx_b, winner, loser;
	logic [CNT_W-1:0]  rd_cnt, sum_cnt;
	logic              roots_same;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign two       = (cmd_q == CMD_MERGE) || (cmd_q == CMD_SAME);
	assign is_merge  = (cmd_q == CMD_MERGE);
	assign idx_a     = IDX_W'(a_q);
	assign idx_b     = IDX_W'(b_q);
	assign start_idx = phase_q ? idx_b : idx_a;

	assign idx_err = !({1'b0, a_q} < node_count_q) || !(32'(a_q) < 32'(MAX_NODES)) ||
		(two && (!({1'b0, b_q} < node_count_q) || !(32'(b_q) < 32'(MAX_NODES))));

	assign rd_parent = rdata_q[IDX_W-1:0];
	assign rd_cnt    = rdata_q[ENT_W-1:IDX_W];
	assign rd_root   = (rd_parent == cur_q);

	// second find leaves its root in root_q/rcnt_q
	assign roots_same = (ra_q == root_q);
	assign winner     = (ca_q < rcnt_q) ? root_q : ra_q;
	assign loser      = (ca_q < rcnt_q) ? ra_q : root_q;
	assign sum_cnt    = ca_q + rcnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(MAX_NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_accept) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = idx_err ? ST_RESP : ST_WALK;
			end
			ST_WALK: begin
				if (rd_root) state_d = ST_COMP;
			end
			ST_COMP: begin
				if (node_q == root_q) begin
					if (!phase_q) state_d = two ? ST_WALK : ST_RESP;
					else if (is_merge && !roots_same) state_d = ST_LINK;
					else state_d = ST_RESP;
				end
			end
			ST_LINK: state_d = ST_SIZE;
			ST_SIZE: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_we) state_d = ST_CLEAR;
	end

	// table port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = {CNT_W'(1), clr_q};
		mem_raddr = idx_a;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_CHECK: begin
				mem_raddr = idx_a;
			end
			ST_WALK: begin
				mem_raddr = rd_root ? start_idx : rd_parent;
			end
			ST_COMP: begin
				if (node_q != root_q) begin
					mem_we    = 1'b1;
					mem_waddr = node_q;
					mem_wdata = {CNT_W'(0), root_q};
					mem_raddr = rd_parent;
				end else begin
					mem_raddr = idx_b;
				end
			end
			ST_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = loser;
				mem_wdata = {CNT_W'(0), winner};
			end
			ST_SIZE: begin
				mem_we    = 1'b1;
				mem_waddr = winner;
				mem_wdata = {sum_cnt, winner};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) table_q[mem_waddr] <= mem_wdata;
		rdata_q <= table_q[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			node_count_q <= CNT_W'(1024);
			clr_q        <= '0;
			m_tvalid_q   <= 1'b0;
			phase_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
				clr_q        <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (s_accept) phase_q <= 1'b0;
			else if (state_q == ST_COMP && node_q == root_q && !phase_q && two)
				phase_q <= 1'b1;
			if (state_q == ST_RESP && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					cmd_q <= cmd_t'(s_tdata[1:0]);
					a_q   <= s_tdata[11:2];
					b_q   <= s_tdata[21:12];
				end
			end
			ST_CHECK: begin
				res_err_q  <= idx_err;
				res_root_q <= '0;
				res_same_q <= 1'b0;
				res_size_q <= '0;
				cur_q      <= idx_a;
			end
			ST_WALK: begin
				if (rd_root) begin
					root_q <= cur_q;
					rcnt_q <= rd_cnt;
					node_q <= start_idx;
				end else begin
					cur_q <= rd_parent;
				end
			end
			ST_COMP: begin
				if (node_q != root_q) begin
					node_q <= rd_parent;
				end else if (!phase_q) begin
					ra_q <= root_q;
					ca_q <= rcnt_q;
					cur_q <= idx_b;
					res_root_q <= NODE_W'(root_q);
					res_size_q <= rcnt_q;
				end else begin
					res_same_q <= roots_same;
					res_root_q <= NODE_W'(ra_q);
					res_size_q <= ca_q;
				end
			end
			ST_LINK: begin
				res_root_q <= NODE_W'(winner);
				res_size_q <= sum_cnt;
			end
			ST_RESP: begin
				if (out_free)
					m_tdata_q <= {1'b0, res_err_q, res_size_q, res_same_q, res_root_q};
			end
			default: begin
			end
		endcase
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_engine_core testbench
// Drives merge, same-set, find and size requests through the stream ports and
// checks every response against a disjoint-set predictor that keeps its own
// node table, with node_count swept through small, large and saturating values.
// ----------------------------------------------------------------------------
module testbench;
	import ufe_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	// response fields from the top bit down, as packed in m_tdata
	typedef struct packed {
		logic              index_error;
		logic [CNT_W-1:0]  set_size;
		logic              same_set;
		logic [NODE_W-1:0] root_node;
	} dsu_result_t;

	class dsu_scoreboard;
		logic [NODE_W-1:0] link_to [TABLE_DEPTH];
		bit                root_mark [TABLE_DEPTH];
		logic [CNT_W-1:0]  member_cnt [TABLE_DEPTH];
		int unsigned       node_limit;
		dsu_result_t       pending_results [$];
		int unsigned       mismatches;

		function new();
			mismatches = 0;
			clear_table(TABLE_DEPTH);
		endfunction

		function void clear_table(int unsigned count);
			node_limit = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				link_to[i] = NODE_W'(i);
				root_mark[i] = 1'b1;
				member_cnt[i] = CNT_W'(1);
			end
		endfunction

		// walk up to the root, then point every node on the path straight at it
		function logic [NODE_W-1:0] locate_root(logic [NODE_W-1:0] node);
			logic [NODE_W-1:0] cur;
			logic [NODE_W-1:0] nxt;
			int unsigned steps;
			cur = node;
			steps = 0;
			while (!root_mark[cur] && steps < TABLE_DEPTH) begin
				cur = link_to[cur];
				steps++;
			end
			steps = 0;
			while (node != cur && steps < TABLE_DEPTH) begin
				nxt = link_to[node];
				link_to[node] = cur;
				node = nxt;
				steps++;
			end
			return cur;
		endfunction

		function void note_request(cmd_t op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
			dsu_result_t res;
			logic [NODE_W-1:0] ra;
			logic [NODE_W-1:0] rb;
			logic [NODE_W-1:0] tmp;
			bit pair;
			res = '0;
			pair = (op == CMD_MERGE || op == CMD_SAME);
			if (a >= node_limit || (pair && b >= node_limit)) begin
				res.index_error = 1'b1;
			end else begin
				ra = locate_root(a);
				if (pair) begin
					rb = locate_root(b);
					res.same_set = (ra == rb);
					if (op == CMD_MERGE && ra != rb) begin
						// larger set keeps its root, a tie goes to node_a's root
						if (member_cnt[ra] < member_cnt[rb]) begin
							tmp = ra;
							ra = rb;
							rb = tmp;
						end
						member_cnt[ra] = member_cnt[ra] + member_cnt[rb];
						link_to[rb] = ra;
						root_mark[rb] = 1'b0;
					end
				end
				res.root_node = ra;
				res.set_size = member_cnt[ra];
			end
			pending_results = {pending_results, res};
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			dsu_result_t got;
			dsu_result_t want;
			got = dsu_result_t'(data[$bits(dsu_result_t)-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: response with none outstanding, actual %h", $time, data);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.root_node !== want.root_node) begin
				$display("%0t: root_node expected %0d actual %0d", $time,
					want.root_node, got.root_node);
				mismatches++;
			end
			if (got.same_set !== want.same_set) begin
				$display("%0t: same_set expected %0b actual %0b", $time,
					want.same_set, got.same_set);
				mismatches++;
			end
			if (got.set_size !== want.set_size) begin
				$display("%0t: set_size expected %0d actual %0d", $time,
					want.set_size, got.set_size);
				mismatches++;
			end
			if (got.index_error !== want.index_error) begin
				$display("%0t: index_error expected %0b actual %0b", $time,
					want.index_error, got.index_error);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // cmd, node_a, node_b, zero pad
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // root_node, same_set, set_size, index_error, zero pad

	dsu_scoreboard board;
	int unsigned   src_idle_pct;
	int unsigned   sink_idle_pct;
	int unsigned   cycle_cnt = 0;

	union_find_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[union_find_engine_core] ERROR");
			$finish;
		end
	end

	// response side: check each transaction, stall at random
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic run_request(cmd_t op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {2'b00, b, a, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_request(op, a, b);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_node_count(logic [CNT_W-1:0] count);
		drain_results();
		cfg_wdata <= count;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.clear_table(count);
	endtask

	// mostly in-range nodes, half of them from a small hot group to build deep sets
	function automatic logic [NODE_W-1:0] pick_node(int unsigned lim);
		int unsigned hot;
		if (lim == 0 || (lim < TABLE_DEPTH && $urandom_range(99) < 10))
			return NODE_W'($urandom_range(TABLE_DEPTH - 1, lim));
		hot = (lim < 32) ? lim : 32;
		if ($urandom_range(1) == 0)
			return NODE_W'($urandom_range(hot - 1));
		return NODE_W'($urandom_range(lim - 1));
	endfunction

	task automatic random_request(int unsigned lim);
		int unsigned roll;
		cmd_t op;
		roll = $urandom_range(99);
		if (roll < 40)
			op = CMD_MERGE;
		else if (roll < 60)
			op = CMD_SAME;
		else if (roll < 80)
			op = CMD_FIND;
		else
			op = CMD_SIZE;
		run_request(op, pick_node(lim), pick_node(lim));
	endtask

	initial begin
		int unsigned counts [10];
		int unsigned loads [10];
		int unsigned lim;
		counts = '{16, 1024, 2047, 2, 200, 1, 64, 0, 1023, 8};
		loads  = '{200, 250, 200, 60, 250, 40, 200, 30, 250, 120};
		board = new();
		src_idle_pct = 6;
		sink_idle_pct = 52;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// full table after reset: ties, larger set winning, repeat merge
		run_request(CMD_FIND, 10'd0, 10'd1023);
		run_request(CMD_SIZE, 10'd1023, 10'd0);
		run_request(CMD_MERGE, 10'd0, 10'd1023);
		run_request(CMD_SAME, 10'd1023, 10'd0);
		run_request(CMD_MERGE, 10'd0, 10'd1023);
		run_request(CMD_MERGE, 10'd1, 10'd2);
		run_request(CMD_MERGE, 10'd2, 10'd1023);
		run_request(CMD_MERGE, 10'd5, 10'd1023);
		run_request(CMD_FIND, 10'd1023, 10'd1023);
		run_request(CMD_SIZE, 10'd5, 10'd0);
		run_request(CMD_SAME, 10'd3, 10'd4);

		// small table: out-of-range on either node, unused node_b ignored
		write_node_count(11'd4);
		run_request(CMD_FIND, 10'd3, 10'd0);
		run_request(CMD_FIND, 10'd4, 10'd0);
		run_request(CMD_SIZE, 10'd1023, 10'd0);
		run_request(CMD_MERGE, 10'd0, 10'd4);
		run_request(CMD_SAME, 10'd4, 10'd0);
		run_request(CMD_MERGE, 10'd3, 10'd0);
		run_request(CMD_FIND, 10'd2, 10'd1023);
		run_request(CMD_SIZE, 10'd0, 10'd1023);

		// empty table: everything fails
		write_node_count(11'd0);
		run_request(CMD_FIND, 10'd0, 10'd0);
		run_request(CMD_MERGE, 10'd0, 10'd0);
		run_request(CMD_SIZE, 10'd0, 10'd0);

		for (int p = 0; p < 10; p++) begin
			write_node_count(CNT_W'(counts[p]));
			if (p == 4) begin
				src_idle_pct = 52;
				sink_idle_pct = 6;
			end else if (p == 7) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			lim = (counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : counts[p];
			repeat (loads[p])
				random_request(lim);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("[union_find_engine_core] OK");
		else
			$display("[union_find_engine_core] ERROR");
		$finish;
	end

endmodule

/* union_find_engine_core.f */
hw/rtl/ufe_pkg.sv
hw/rtl/union_find_engine_core.sv
verif/testbench.sv
